[rtl/lcf_pkg.sv]
// package for the rgb565 low depth color fix unit
// holds pixel types, correction limits and channel expansion functions
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lcf_pkg;

    localparam int PIXEL_W = 16;
    localparam int CHAN_W  = 8;

    typedef logic [PIXEL_W-1:0] t_pixel;
    typedef logic [CHAN_W-1:0]  t_chan;

    localparam t_chan DARK_LIMIT   = 8'd20;
    localparam t_chan BRIGHT_LIMIT = 8'd220;
    localparam t_chan GREY_SPREAD  = 8'd12;
    localparam t_chan TINT_MARGIN  = 8'd8;
    localparam t_pixel WHITE_PIXEL = 16'hFFFF;
    localparam t_pixel BLACK_PIXEL = 16'h0000;
    localparam logic ENABLE_RESET  = 1'b1;

    // v * 255 / 31 = 8v + floor(7v / 31)
    function automatic t_chan expand5(input logic [4:0] v);
        logic [2:0] frac;
        frac = 3'((v >= 5'd5) ? 1 : 0) + 3'((v >= 5'd9) ? 1 : 0)
             + 3'((v >= 5'd14) ? 1 : 0) + 3'((v >= 5'd18) ? 1 : 0)
             + 3'((v >= 5'd23) ? 1 : 0) + 3'((v >= 5'd27) ? 1 : 0)
             + 3'((v == 5'd31) ? 1 : 0);
        return {v, 3'b000} + {5'd0, frac};
    endfunction

    // v * 255 / 63 ~ 4v + min(floor(v / 21), 2); an input of 63 gives 254, not 255
    function automatic t_chan expand6(input logic [5:0] v);
        logic [1:0] frac;
        frac = 2'((v >= 6'd21) ? 1 : 0) + 2'((v >= 6'd42) ? 1 : 0);
        return {v, 2'b00} + {6'd0, frac};
    endfunction

endpackage

`default_nettype wire

[rtl/lcf_pix_in_if.sv]
// input pixel channel: valid, ready and one rgb565 pixel
// depends on lcf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lcf_pix_in_if
    import lcf_pkg::*;
;
    logic   valid;
    logic   ready;
    t_pixel pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

[rtl/lcf_pix_out_if.sv]
// output pixel channel: valid, ready and one corrected rgb565 pixel
// depends on lcf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lcf_pix_out_if
    import lcf_pkg::*;
;
    logic   valid;
    logic   ready;
    t_pixel pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink (input valid, input pixel_out, output ready);
endinterface

`default_nettype wire

[rtl/lcf_cfg_if.sv]
// configuration write channel carrying the enable register value
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface lcf_cfg_if;
    logic valid;
    logic ready;
    logic low_depth_enable;

    modport source (output valid, output low_depth_enable, input ready);
    modport sink (input valid, input low_depth_enable, output ready);
endinterface

`default_nettype wire

[rtl/lcf_cfg_reg.sv]
// enable register written through the configuration channel
// depends on lcf_pkg and lcf_cfg_if
`timescale 1ns / 1ps
`default_nettype none

module lcf_cfg_reg
    import lcf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lcf_cfg_if.sink    i_cfg,
    output logic       o_enable
);

    logic r_enable;
    logic n_enable;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_enable = r_enable;
        if (i_cfg.valid) begin
            n_enable = i_cfg.low_depth_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= ENABLE_RESET;
        end else begin
            r_enable <= n_enable;
        end
    end

    assign o_enable = r_enable;

endmodule

`default_nettype wire

[rtl/lcf_correct.sv]
// combinational color correction of one rgb565 pixel
// depends on lcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcf_correct
    import lcf_pkg::*;
(
    input  wire logic   i_enable,
    input  wire t_pixel i_pixel,
    output t_pixel      o_pixel
);

    t_chan      red;
    t_chan      green;
    t_chan      blue;
    t_chan      hi;
    t_chan      lo;
    t_chan      rb_max;
    t_chan      rb_min;
    t_chan      rb_diff;
    t_chan      green_fix;
    logic [8:0] red_m;
    logic [8:0] blue_m;
    logic       tint;

    always_comb begin
        red    = expand5(i_pixel[15:11]);
        green  = expand6(i_pixel[10:5]);
        blue   = expand5(i_pixel[4:0]);
        rb_max = (red > blue) ? red : blue;
        rb_min = (red > blue) ? blue : red;
        hi     = (green > rb_max) ? green : rb_max;
        lo     = (green < rb_min) ? green : rb_min;
        rb_diff = rb_max - rb_min;
        red_m  = {1'b0, red} + {1'b0, TINT_MARGIN};
        blue_m = {1'b0, blue} + {1'b0, TINT_MARGIN};
        tint   = (rb_diff < GREY_SPREAD) && ({1'b0, green} > red_m)
                 && ({1'b0, green} > blue_m);
        green_fix = tint ? rb_max : green;

        if (!i_enable) begin
            o_pixel = i_pixel;
        end else if (hi < DARK_LIMIT) begin
            o_pixel = BLACK_PIXEL;
        end else if (lo > BRIGHT_LIMIT) begin
            o_pixel = WHITE_PIXEL;
        end else begin
            o_pixel = {red[7:3], green_fix[7:2], blue[7:3]};
        end
    end

endmodule

`default_nettype wire

[rtl/rgb565_low_depth_color_fix_unit.sv]
// top level of the rgb565 low depth color fix unit
// depends on lcf_pkg, the channel interfaces, lcf_cfg_reg and lcf_correct
//
// usage:
// - i_pix takes one rgb565 pixel per transaction (valid and ready both high)
// - o_pix gives one corrected pixel per accepted input pixel, in order
// - i_cfg writes the enable bit; it is always ready and should be used only
//   while no pixel is in flight
// - with enable set, channels are widened to 8 bits, near-black pixels go
//   to black, near-white pixels go to white, a green cast on grey pixels is
//   removed and the channels are packed back to rgb565
// - with enable clear, pixels pass unchanged
// - a pixel is held in an input register, corrected by one level of
//   combinational logic and captured in the result register
// - a pixel waits in the input register until the result register is free,
//   then it is captured in the result register and offered on o_pix
// - throughput: one pixel per cycle while o_pix is ready
// - when o_pix stalls, the result register and then the input register
//   hold their pixels and i_pix ready drops once both are full
// - synchronous active-low reset empties both registers and sets enable
`timescale 1ns / 1ps
`default_nettype none

module rgb565_low_depth_color_fix_unit
    import lcf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    lcf_pix_in_if.sink    i_pix,
    lcf_pix_out_if.source o_pix,
    lcf_cfg_if.sink       i_cfg
);

    logic   enable;
    logic   r_s1_valid;
    logic   n_s1_valid;
    t_pixel r_s1_pixel;
    logic   r_s2_valid;
    logic   n_s2_valid;
    t_pixel r_s2_pixel;
    t_pixel fixed_pixel;
    logic   s2_free;
    logic   s1_free;
    logic   s1_move;
    logic   in_take;

    lcf_cfg_reg u_cfg_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_enable (enable)
    );

    lcf_correct u_correct (
        .i_enable (enable),
        .i_pixel  (r_s1_pixel),
        .o_pixel  (fixed_pixel)
    );

    assign s2_free     = !r_s2_valid || o_pix.ready;
    assign s1_move     = r_s1_valid && s2_free;
    assign s1_free     = !r_s1_valid || s2_free;
    assign in_take     = i_pix.valid && s1_free;
    assign i_pix.ready = s1_free;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (s1_free) begin
            n_s1_valid = i_pix.valid;
        end
        n_s2_valid = r_s2_valid;
        if (s2_free) begin
            n_s2_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_pixel <= i_pix.pixel_in;
        end
        if (s1_move) begin
            r_s2_pixel <= fixed_pixel;
        end
    end

    assign o_pix.valid     = r_s2_valid;
    assign o_pix.pixel_out = r_s2_pixel;

    a_s1_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_free |=> r_s1_valid && $stable(r_s1_pixel))
        else $error("input register lost a pixel while stalled");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> r_s1_valid && r_s2_valid)
        else $error("input stalled with free register space");

    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && !enable |=> r_s2_pixel == $past(r_s1_pixel))
        else $error("disabled correction changed a pixel");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && enable && r_s1_pixel == BLACK_PIXEL |=> r_s2_pixel == BLACK_PIXEL)
        else $error("black pixel not kept black");

endmodule

`default_nettype wire
